### hw/rtl/led_strip_pattern_generator_defines.svh
// Assertion macros shared by the LED strip pattern generator RTL.
`ifndef LED_STRIP_PATTERN_GENERATOR_DEFINES_SVH
`define LED_STRIP_PATTERN_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cond implies fact at every clock edge out of reset.
`define LSP_ASSERT_IMPL(label, cond, fact) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (fact)) \
        else $error("lsp assertion failed");
// Check that cond implies fact at the next clock edge out of reset.
`define LSP_ASSERT_NEXT(label, cond, fact) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (fact)) \
        else $error("lsp assertion failed");
`else
`define LSP_ASSERT_IMPL(label, cond, fact)
`define LSP_ASSERT_NEXT(label, cond, fact)
`endif

`endif

### hw/rtl/lsp_pkg.sv
// Shared types, codes and color functions of the LED strip pattern generator.
`default_nettype none
package lsp_pkg;

    localparam int DEF_MAX_PIXELS = 256;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;
    localparam int DIV_DW         = 25;
    localparam int DIV_VW         = 16;

    // Pattern codes
    localparam logic [2:0] MODE_SOLID   = 3'd0;
    localparam logic [2:0] MODE_RAINBOW = 3'd1;
    localparam logic [2:0] MODE_CHASE   = 3'd2;
    localparam logic [2:0] MODE_WIPE    = 3'd3;
    localparam logic [2:0] MODE_FADE    = 3'd4;
    localparam logic [2:0] MODE_SPACED  = 3'd5;
    localparam logic [2:0] MODE_FESTIVE = 3'd6;

    // Step advance codes
    localparam logic [1:0] ADV_FWD = 2'd1;
    localparam logic [1:0] ADV_REV = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_COLOR_A = 3'd1;
    localparam logic [2:0] REG_COLOR_B = 3'd2;
    localparam logic [2:0] REG_FADE    = 3'd3;
    localparam logic [2:0] REG_BAND_W  = 3'd4;
    localparam logic [2:0] REG_SPACING = 3'd5;
    localparam logic [2:0] REG_STRIP   = 3'd6;
    localparam logic [2:0] REG_ADVANCE = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_DIV,
        S_WAIT,
        S_FIN
    } lsp_state_t;

    typedef struct packed {
        logic       load_in;
        logic       do_mul;
        logic       do_sum;
        logic       div_start;
        logic       div_store;
        logic       finish;
        logic [1:0] job;
    } lsp_cmd_t;

    typedef struct packed {
        logic [1:0] njobs;
        logic       div_done;
        logic       out_free;
    } lsp_sts_t;

    function automatic logic [23:0] festive_color(input logic [2:0] sel);
        logic [23:0] c;
        case (sel)
            3'd1:    c = 24'hdda400;
            3'd2:    c = 24'h1188ff;
            3'd3:    c = 24'h00ee22;
            3'd4:    c = 24'haa0044;
            default: c = 24'hdd0000;
        endcase
        return c;
    endfunction

    // Rainbow spread per band width; out-of-range widths clamp to 1..10.
    function automatic logic [9:0] rainbow_spread(input logic [3:0] w);
        logic [9:0] s;
        case (w)
            4'd2:    s = 10'd455;
            4'd3:    s = 10'd398;
            4'd4:    s = 10'd341;
            4'd5:    s = 10'd284;
            4'd6:    s = 10'd228;
            4'd7:    s = 10'd171;
            4'd8:    s = 10'd114;
            4'd9:    s = 10'd57;
            4'd0,
            4'd1:    s = 10'd512;
            default: s = 10'd1;
        endcase
        return s;
    endfunction

    function automatic logic [23:0] wheel(input logic [7:0] pos);
        logic [7:0]  w;
        logic [7:0]  k;
        logic [23:0] c;
        w = 8'd255 - pos;
        if (w < 8'd85) begin
            k = 8'(w * 8'd3);
            c = {8'd255 - k, 8'd0, k};
        end else if (w < 8'd170) begin
            k = 8'((w - 8'd85) * 8'd3);
            c = {8'd0, k, 8'd255 - k};
        end else begin
            k = 8'((w - 8'd170) * 8'd3);
            c = {k, 8'd255 - k, 8'd0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/lsp_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module lsp_div #(
    parameter int DW = lsp_pkg::DIV_DW,
    parameter int VW = lsp_pkg::DIV_VW
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quot,
    output logic [VW-1:0]      rem
);
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dsr_reg, dsr_next;
    logic [VW:0]   shifted;
    logic [VW+1:0] trial;
    logic          ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DW-1]};
        trial     = {1'b0, shifted} - {2'b0, dsr_reg};
        ge        = !trial[VW+1];
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CW'(DW);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            quo_next  = {quo_reg[DW-2:0], ge};
            rem_next  = ge ? trial[VW-1:0] : shifted[VW-1:0];
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;
endmodule
`default_nettype wire

### hw/rtl/lsp_ctrl.sv
// Controller state machine that sequences the divide jobs of one request.
`default_nettype none
`include "led_strip_pattern_generator_defines.svh"
module lsp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire lsp_pkg::lsp_sts_t sts,
    output lsp_pkg::lsp_cmd_t      cmd
);
    import lsp_pkg::*;

    lsp_state_t state_reg, state_next;
    logic [1:0] job_reg, job_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        case (state_reg)
            S_IDLE:
            begin
                job_next = 2'd0;
                if (in_valid)
                    state_next = (sts.njobs == 2'd0) ? S_FIN : S_MUL;
            end
            S_MUL:  state_next = S_SUM;
            S_SUM:  state_next = S_DIV;
            S_DIV:  state_next = S_WAIT;
            S_WAIT:
            begin
                if (sts.div_done)
                begin
                    if (job_reg + 2'd1 == sts.njobs)
                        state_next = S_FIN;
                    else
                    begin
                        job_next   = job_reg + 2'd1;
                        state_next = S_MUL;
                    end
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd           = '0;
        cmd.job       = job_reg;
        cmd.load_in   = (state_reg == S_IDLE) && in_valid;
        cmd.do_mul    = (state_reg == S_MUL);
        cmd.do_sum    = (state_reg == S_SUM);
        cmd.div_start = (state_reg == S_DIV);
        cmd.div_store = (state_reg == S_WAIT) && sts.div_done;
        cmd.finish    = (state_reg == S_FIN) && sts.out_free;
        in_stall      = (state_reg != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= 2'd0;
        end else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    `LSP_ASSERT_IMPL(a_job_range, 1'b1, job_reg != 2'd3)
    `LSP_ASSERT_IMPL(a_done_in_wait, sts.div_done, state_reg == S_WAIT)
    `LSP_ASSERT_NEXT(a_accept_busy, cmd.load_in, state_reg != S_IDLE)
endmodule
`default_nettype wire

### hw/rtl/lsp_dp.sv
// Datapath: registers, operand selection, divider, color and step logic.
`default_nettype none
module lsp_dp #(
    parameter int MAX_PIXELS = lsp_pkg::DEF_MAX_PIXELS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [lsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lsp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [7:0]                    pixel_number,
    input  wire logic                          frame_end,
    input  wire logic                          out_stall,
    output logic                               out_valid,
    output logic [7:0]                         pixel_out,
    output logic [23:0]                        pixel_color,
    output logic                               write_pixel,
    output logic                               cycle_done,
    input  wire lsp_pkg::lsp_cmd_t             cmd,
    output lsp_pkg::lsp_sts_t                  sts
);
    import lsp_pkg::*;

    logic [2:0]  mode_reg;
    logic [23:0] ca_reg, cb_reg;
    logic [15:0] fade_reg;
    logic [3:0]  bw_reg;
    logic [7:0]  sp_reg;
    logic [8:0]  strip_reg;
    logic [1:0]  adv_reg;
    logic [15:0] step_reg, step_next;
    logic [2:0]  bcs_reg, bcs_next;

    logic [7:0]  p_reg;
    logic        fend_reg;
    logic [23:0] mul_reg;
    logic signed [25:0] num_reg;
    logic [15:0] dsr_reg;
    logic [7:0]  qlo_reg;
    logic [7:0]  chan_reg [3];
    logic [7:0]  rem0_reg, rem1_reg;

    logic        ov_reg;
    logic [7:0]  po_reg;
    logic [23:0] pc_reg;
    logic        wp_reg, cd_reg;

    logic [8:0]  n_sat;
    logic [7:0]  sp_eff;
    logic [7:0]  ca_c, cb_c;
    logic signed [8:0] diff;
    logic        div_done;
    logic [DIV_DW-1:0] quot;
    logic [DIV_VW-1:0] rem;
    logic [DIV_DW-1:0] dividend;
    logic [2:0]  bcs_eff;
    logic [23:0] color;
    logic        wr, done, steps, lit;
    logic [15:0] wrap, inc, dec;

    always_comb
    begin
        if (strip_reg == 9'd0)
            n_sat = 9'd1;
        else if (strip_reg > 9'(MAX_PIXELS))
            n_sat = 9'(MAX_PIXELS);
        else
            n_sat = strip_reg;
        sp_eff = (sp_reg == 8'd0) ? 8'd1 : sp_reg;
        case (cmd.job)
            2'd0:    begin ca_c = ca_reg[23:16]; cb_c = cb_reg[23:16]; end
            2'd1:    begin ca_c = ca_reg[15:8];  cb_c = cb_reg[15:8];  end
            default: begin ca_c = ca_reg[7:0];   cb_c = cb_reg[7:0];   end
        endcase
        diff = $signed({1'b0, cb_c}) - $signed({1'b0, ca_c});
        case (mode_reg)
            MODE_RAINBOW, MODE_SPACED, MODE_FESTIVE: sts.njobs = 2'd1;
            MODE_CHASE: sts.njobs = 2'd2;
            MODE_FADE:  sts.njobs = (fade_reg == 16'd0) ? 2'd0 : 2'd3;
            default:    sts.njobs = 2'd0;
        endcase
        sts.div_done = div_done;
        sts.out_free = !ov_reg || !out_stall;
        dividend = num_reg[25] ? '0 : num_reg[24:0];
    end

    lsp_div #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (dsr_reg),
        .done     (div_done),
        .quot     (quot),
        .rem      (rem)
    );

    // Operand path: multiply, then sum, then divide.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            p_reg    <= pixel_number;
            fend_reg <= frame_end;
        end
        if (cmd.do_mul)
        begin
            if (mode_reg == MODE_FADE)
                mul_reg <= ca_c * fade_reg;
            else
                mul_reg <= 24'({9'd0, p_reg} * {7'd0, rainbow_spread(bw_reg)});
        end
        if (cmd.do_sum)
        begin
            case (mode_reg)
                MODE_RAINBOW:
                begin
                    num_reg <= $signed({2'b0, mul_reg});
                    dsr_reg <= {7'd0, n_sat};
                end
                MODE_FADE:
                begin
                    num_reg <= $signed({2'b0, mul_reg}) + diff * $signed({1'b0, step_reg});
                    dsr_reg <= fade_reg;
                end
                MODE_CHASE:
                begin
                    num_reg <= (cmd.job == 2'd0)
                               ? $signed({9'd0, {9'd0, p_reg} + {1'b0, step_reg}})
                               : $signed({17'd0, n_sat});
                    dsr_reg <= {8'd0, sp_eff};
                end
                default:
                begin
                    num_reg <= $signed({18'd0, p_reg});
                    dsr_reg <= {8'd0, sp_eff};
                end
            endcase
        end
        if (cmd.div_store)
        begin
            chan_reg[cmd.job] <= (quot > DIV_DW'(255)) ? 8'd255 : quot[7:0];
            if (cmd.job == 2'd0)
            begin
                qlo_reg  <= quot[7:0];
                rem0_reg <= rem[7:0];
            end
            if (cmd.job == 2'd1)
                rem1_reg <= rem[7:0];
        end
    end

    // Color, write flag and step update
    always_comb
    begin
        bcs_eff  = (p_reg == 8'd0) ? 3'd0 : bcs_reg;
        bcs_next = bcs_eff;
        color    = 24'd0;
        wr       = 1'b1;
        steps    = mode_reg inside {[MODE_RAINBOW:MODE_FADE]};
        lit      = rem0_reg < {4'd0, bw_reg};
        wrap     = 16'd0;
        case (mode_reg)
            MODE_SOLID:   color = ca_reg;
            MODE_RAINBOW:
            begin
                color = wheel(qlo_reg + step_reg[7:0]);
                wrap  = 16'd255;
            end
            MODE_CHASE:
            begin
                color = lit ? ca_reg : cb_reg;
                wrap  = {7'd0, n_sat - {1'b0, rem1_reg}};
            end
            MODE_WIPE:
            begin
                wr    = ({8'd0, p_reg} == step_reg);
                color = wr ? ca_reg : 24'd0;
                wrap  = {7'd0, n_sat};
            end
            MODE_FADE:
            begin
                color = (fade_reg == 16'd0) ? ca_reg
                                            : {chan_reg[0], chan_reg[1], chan_reg[2]};
                wrap  = fade_reg;
            end
            MODE_SPACED:
            begin
                if (lit)
                    color = p_reg[0] ? cb_reg : ca_reg;
            end
            MODE_FESTIVE:
            begin
                if (lit)
                begin
                    color = festive_color((bcs_eff < 3'd5) ? bcs_eff : 3'd0);
                    if (rem0_reg == {4'd0, bw_reg - 4'd1})
                        bcs_next = (bcs_eff + 3'd1 >= 3'd5) ? 3'd0 : bcs_eff + 3'd1;
                end
            end
            default: wr = 1'b0;
        endcase

        inc       = step_reg + 16'd1;
        dec       = step_reg - 16'd1;
        step_next = step_reg;
        done      = 1'b0;
        if (steps && fend_reg)
        begin
            if (adv_reg == ADV_FWD)
            begin
                step_next = (inc >= wrap) ? 16'd0 : inc;
                done      = (inc >= wrap);
            end else if (adv_reg == ADV_REV)
            begin
                step_next = (dec == 16'd0) ? wrap - 16'd1 : dec;
                done      = (dec == 16'd0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SOLID;
            ca_reg    <= '0;
            cb_reg    <= '0;
            fade_reg  <= 16'd1;
            bw_reg    <= 4'd1;
            sp_reg    <= 8'd1;
            strip_reg <= 9'd1;
            adv_reg   <= '0;
            step_reg  <= '0;
            bcs_reg   <= '0;
            ov_reg    <= 1'b0;
        end else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MODE:
                    begin
                        mode_reg <= cfg_data[2:0];
                        step_reg <= '0;
                    end
                    REG_COLOR_A: ca_reg    <= cfg_data;
                    REG_COLOR_B: cb_reg    <= cfg_data;
                    REG_FADE:    fade_reg  <= cfg_data[15:0];
                    REG_BAND_W:  bw_reg    <= cfg_data[3:0];
                    REG_SPACING: sp_reg    <= cfg_data[7:0];
                    REG_STRIP:   strip_reg <= cfg_data[8:0];
                    REG_ADVANCE: adv_reg   <= cfg_data[1:0];
                    default: ;
                endcase
            end else if (cmd.finish)
            begin
                step_reg <= step_next;
                bcs_reg  <= bcs_next;
            end
            if (cmd.finish)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            po_reg <= p_reg;
            pc_reg <= color;
            wp_reg <= wr;
            cd_reg <= done;
        end
    end

    assign out_valid   = ov_reg;
    assign pixel_out   = po_reg;
    assign pixel_color = pc_reg;
    assign write_pixel = wp_reg;
    assign cycle_done  = cd_reg;
endmodule
`default_nettype wire

### hw/rtl/led_strip_pattern_generator.sv
// Top level of the LED strip pattern generator.
`default_nettype none
// Turns pixel requests into 24-bit colors (red 23:16, green 15:8, blue 7:0)
// for seven patterns: solid, rainbow wheel, theater chase, color wipe,
// two-color fade, spaced lights and five-color festive bands. Requests must
// arrive in pixel order; frame_end marks the last pixel of a frame, and on it
// the step index moves forward or back in the stepping patterns, with
// cycle_done raised when it wraps. Writing the pattern register clears the
// step index. Configure only while no request is in flight. One request is
// worked at a time: a request that needs no division (solid, wipe, unused
// code, fade with zero length) goes from the idle state straight to the
// finish state, which registers the result when the output is free.
// Each division on the shared one-bit-per-cycle 25-bit divider adds the
// steps multiply, sum, start, 25 quotient bits and store; rainbow, spaced
// and festive need one division, chase two and fade three. The result is
// held in an output register, so a new request is taken while an earlier
// result is still stalled; the finishing cycle of that new request waits
// until the output register is free.
module led_strip_pattern_generator #(
    parameter int MAX_PIXELS = lsp_pkg::DEF_MAX_PIXELS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [lsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lsp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    pixel_number,
    input  wire logic                          frame_end,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [7:0]                         pixel_out,
    output logic [23:0]                        pixel_color,
    output logic                               write_pixel,
    output logic                               cycle_done
);
    import lsp_pkg::*;

    lsp_cmd_t cmd;
    lsp_sts_t sts;

    // Sequence each request's divide jobs
    lsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold configuration, step state and the output register
    lsp_dp #(.MAX_PIXELS(MAX_PIXELS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_number (pixel_number),
        .frame_end    (frame_end),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .pixel_out    (pixel_out),
        .pixel_color  (pixel_color),
        .write_pixel  (write_pixel),
        .cycle_done   (cycle_done),
        .cmd          (cmd),
        .sts          (sts)
    );
endmodule
`default_nettype wire
